// ----- rtl/core/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared constants and round helpers for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned NUM_WORDS = 5;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_FILL  = 7'b1000000
  } state_e;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20)      round_k = K0;
    else if (t < 7'd40) round_k = K1;
    else if (t < 7'd60) round_k = K2;
    else                round_k = K3;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (t < 7'd20)      round_f = (b & c) | (~b & d);
    else if (t < 7'd40) round_f = b ^ c ^ d;
    else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else                round_f = b ^ c ^ d;
  endfunction

  function automatic logic [31:0] init_word(input logic [2:0] i);
    case (i)
      3'd0:    init_word = H0;
      3'd1:    init_word = H1;
      3'd2:    init_word = H2;
      3'd3:    init_word = H3;
      default: init_word = H4;
    endcase
  endfunction

endpackage

// ----- rtl/core/sha1_ram.sv -----
// ----------------------------------------------------------------------------
// SHA-1 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sha1_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/sha1_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-serial SHA-1 digest with a 16-word block memory and one round a cycle.
// ----------------------------------------------------------------------------
// Usage: feed message bytes on the s_axis channel, one byte per handshake.
// tdata carries data_byte; tuser carries byte_valid; tlast carries
// end_of_message. An item with tuser low only finishes a message when tlast
// is high, else it is dropped.
// Message bytes are packed into 32-bit words in a 16-entry block RAM. A byte
// that closes a block starts the compression: a load step, 80 rounds (one
// SHA-1 round per cycle; the first 16 schedule words are read from the block
// RAM, the rest are formed from a 16-word register window), then an add into
// the chaining words.
// End of message writes padding and length one RAM word per cycle up to the
// last RAM word, runs one or two compressions, then emits five digest words on
// m_axis, h0 first, tlast on h4; tuser carries word_number. The receiver may
// stall m_axis at any time; the engine holds the word and accepts no input
// until all five are taken and the SHA-1 initial chaining values are restored.
// Reset clears control state and sets the chaining words to those initial values.
module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_number
  output logic        m_axis_tlast    // last_word
);

  sha1_pkg::state_e state_q, state_d;

  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  t_q;
  logic [5:0]  fill_q;
  logic [60:0] cnt_q;
  logic [23:0] part_q;      // bytes of the word being built
  logic [3:0]  pidx_q;      // padding word index
  logic        second_q;    // a second padded block follows
  logic        fin_q;       // pad byte already placed in an earlier block
  logic        pend_q;      // end of message waits for the block compression
  logic        padblk_q;    // current compression runs on a padded block
  logic [2:0]  widx_q;
  logic [31:0] wcur;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  sha1_ram #(.Width(32), .Depth(16)) u_block (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic        in_acc, out_acc;
  logic [1:0]  blane;
  logic [31:0] byte_word;
  logic [31:0] sched;
  logic [31:0] mix;
  logic [31:0] tmp;
  logic [63:0] bits;
  logic [5:0]  pos;         // first pad byte position
  logic [5:0]  pos_next;    // fill after this item's byte
  logic [31:0] pad_word;
  logic [3:0]  pad_first;
  logic [31:0] win_q [16];

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (state_q == sha1_pkg::ST_IDLE);

  assign m_axis_tvalid = (state_q == sha1_pkg::ST_EMIT);
  assign m_axis_tdata  = h_q[widx_q];
  assign m_axis_tuser  = widx_q;
  assign m_axis_tlast  = (widx_q == 3'(sha1_pkg::NUM_WORDS - 1));

  assign blane = fill_q[1:0];
  always_comb begin
    case (blane)
      2'd0:    byte_word = {s_axis_tdata, 24'h0};
      2'd1:    byte_word = {part_q[23:16], s_axis_tdata, 16'h0};
      2'd2:    byte_word = {part_q[23:8], s_axis_tdata, 8'h0};
      default: byte_word = {part_q, s_axis_tdata};
    endcase
  end

  // Pad position: after a byte in the same item the fill moves on.
  assign bits = {cnt_q, 3'b000};
  assign pos  = fill_q;
  assign pad_first = pos[5:2];
  assign pos_next = s_axis_tuser ? fill_q + 6'd1 : fill_q;

  // Padding word at index pidx_q for block 0 (or 1 if second_q)
  always_comb begin
    logic [31:0] w;
    w = 32'h0;
    if (pidx_q == pad_first && !fin_q) begin
      case (pos[1:0])
        2'd0:    w = {sha1_pkg::PAD_BYTE, 24'h0};
        2'd1:    w = {part_q[23:16], sha1_pkg::PAD_BYTE, 16'h0};
        2'd2:    w = {part_q[23:8], sha1_pkg::PAD_BYTE, 8'h0};
        default: w = {part_q, sha1_pkg::PAD_BYTE};
      endcase
    end
    if (!second_q || fin_q) begin
      if (pidx_q == 4'd14) w = bits[63:32];
      if (pidx_q == 4'd15) w = bits[31:0];
    end
    pad_word = w;
  end

  // Schedule: the first 16 words come from the block RAM, later ones from
  // the rolling 16-word window.
  assign mix   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign sched = (t_q < 7'd16) ? rdata : {mix[30:0], mix[31]};
  assign wcur  = sched;
  assign tmp = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(t_q, b_q, c_q, d_q)
             + e_q + sha1_pkg::round_k(t_q) + wcur;

  always_comb begin
    we    = 1'b0;
    waddr = fill_q[5:2];
    wdata = byte_word;
    raddr = 4'd0;
    state_d = state_q;
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser && (blane == 2'd3 || s_axis_tlast)) begin
            we = 1'b1;
          end
          if (s_axis_tuser && fill_q == 6'd63) state_d = sha1_pkg::ST_LOAD;
          else if (s_axis_tlast) state_d = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_PAD: begin
        we    = 1'b1;
        waddr = pidx_q;
        wdata = pad_word;
        if (pidx_q == 4'd15) state_d = sha1_pkg::ST_LOAD;
      end
      sha1_pkg::ST_LOAD: begin
        raddr = 4'd0;
        state_d = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        raddr = 4'(t_q + 7'd1);
        if (t_q == 7'd79) state_d = sha1_pkg::ST_ADD;
      end
      sha1_pkg::ST_ADD: begin
        if (!padblk_q)              state_d = pend_q ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
        else if (second_q && !fin_q) state_d = sha1_pkg::ST_PAD;
        else                        state_d = sha1_pkg::ST_EMIT;
      end
      sha1_pkg::ST_EMIT: begin
        if (out_acc && m_axis_tlast) state_d = sha1_pkg::ST_FILL;
      end
      sha1_pkg::ST_FILL: begin
        state_d = sha1_pkg::ST_IDLE;
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha1_pkg::ST_IDLE;
      fill_q   <= '0;
      cnt_q    <= '0;
      part_q   <= '0;
      pidx_q   <= '0;
      second_q <= 1'b0;
      fin_q    <= 1'b0;
      pend_q   <= 1'b0;
      padblk_q <= 1'b0;
      widx_q   <= '0;
      t_q      <= '0;
      a_q      <= '0;
      b_q      <= '0;
      c_q      <= '0;
      d_q      <= '0;
      e_q      <= '0;
      for (int i = 0; i < 16; i++) win_q[i] <= '0;
      for (int i = 0; i < 5; i++) h_q[i] <= sha1_pkg::init_word(3'(i));
    end else begin
      state_q <= state_d;
      unique case (state_q)
        sha1_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              part_q <= byte_word[31:8];
              fill_q <= fill_q + 6'd1;
              cnt_q  <= cnt_q + 61'd1;
            end
            fin_q    <= 1'b0;
            padblk_q <= 1'b0;
            second_q <= 1'b0;
            pend_q   <= 1'b0;
            if (s_axis_tuser && fill_q == 6'd63) begin
              // block closes on this byte; if it ends the message, the pad goes into a new block
              pend_q <= s_axis_tlast;
            end else if (s_axis_tlast) begin
              pidx_q   <= pos_next[5:2];
              second_q <= (pos_next > 6'd55);
            end
          end
        end
        sha1_pkg::ST_PAD: begin
          pidx_q <= pidx_q + 4'd1;
          if (pidx_q == 4'd15) padblk_q <= 1'b1;
        end
        sha1_pkg::ST_LOAD: begin
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          t_q <= '0;
        end
        sha1_pkg::ST_ROUND: begin
          e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= tmp;
          for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
          win_q[15] <= wcur;
          t_q <= t_q + 7'd1;
        end
        sha1_pkg::ST_ADD: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
          fill_q <= '0;
          pidx_q <= '0;
          widx_q <= '0;
          if (!padblk_q) begin
            pend_q <= 1'b0;
          end else if (second_q && !fin_q) begin
            fin_q <= 1'b1;
          end
        end
        sha1_pkg::ST_EMIT: begin
          if (out_acc) widx_q <= m_axis_tlast ? 3'd0 : widx_q + 3'd1;
        end
        sha1_pkg::ST_FILL: begin
          for (int i = 0; i < 5; i++) h_q[i] <= sha1_pkg::init_word(3'(i));
          fill_q <= '0;
          cnt_q  <= '0;
          widx_q <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sha1_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-1 engine port checker
// Watches the stream ports of the engine over time.
// ----------------------------------------------------------------------------
module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled digest word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest word changed under stall");

  // tlast marks word four only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
    else $error("tlast not on word four");

  // no input taken while the digest is out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready during digest");

  // words advance by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
    else $error("word number skipped");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
